>>> src/dtia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtia_pkg
// Shared types and constants for the dual timer interrupt adapter.
// ----------------------------------------------------------------------------
package dtia_pkg;

  // Command codes carried by each input item.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Register addresses.
  localparam logic [3:0] ADDR_PRA  = 4'd0;
  localparam logic [3:0] ADDR_PRB  = 4'd1;
  localparam logic [3:0] ADDR_DDRA = 4'd2;
  localparam logic [3:0] ADDR_DDRB = 4'd3;
  localparam logic [3:0] ADDR_TALO = 4'd4;
  localparam logic [3:0] ADDR_TAHI = 4'd5;
  localparam logic [3:0] ADDR_TBLO = 4'd6;
  localparam logic [3:0] ADDR_TBHI = 4'd7;
  localparam logic [3:0] ADDR_ICR  = 4'd13;
  localparam logic [3:0] ADDR_CRA  = 4'd14;
  localparam logic [3:0] ADDR_CRB  = 4'd15;

  // Stage bit positions in the delay pipeline.
  localparam int CA0 = 0;
  localparam int CA1 = 1;
  localparam int CA2 = 2;
  localparam int CA3 = 3;
  localparam int CB0 = 4;
  localparam int CB1 = 5;
  localparam int CB2 = 6;
  localparam int CB3 = 7;
  localparam int LA0 = 8;
  localparam int LA1 = 9;
  localparam int LA2 = 10;
  localparam int LB0 = 11;
  localparam int LB1 = 12;
  localparam int LB2 = 13;
  localparam int P6L0 = 14;
  localparam int P6L1 = 15;
  localparam int P7L0 = 16;
  localparam int P7L1 = 17;
  localparam int I0 = 18;
  localparam int I1 = 19;
  localparam int OSA = 20;
  localparam int OSB = 21;

  localparam int STAGE_W = 22;
  localparam logic [STAGE_W-1:0] STAGE_KEEP = 22'h0AB6EE;

  // Control bit patterns.
  localparam logic [7:0] RUN_MASK_A = 8'h21;
  localparam logic [7:0] RUN_MASK_B = 8'h61;
  localparam logic [7:0] CASCADE_A = 8'h41;
  localparam logic [7:0] CASCADE_GATED = 8'h61;

  // Complete adapter state.
  typedef struct packed {
    logic [15:0]        count_a;
    logic [15:0]        reload_a;
    logic [15:0]        count_b;
    logic [15:0]        reload_b;
    logic [7:0]         control_a;
    logic [7:0]         control_b;
    logic [STAGE_W-1:0] stage_bits;
    logic [3:0]         feed_bits;
    logic [4:0]         int_status;
    logic [4:0]         int_mask;
    logic               line_high;
    logic [1:0]         pin_mode;
    logic [1:0]         pin_level;
    logic [1:0]         toggle_bits;
    logic [7:0]         latch_a;
    logic [7:0]         latch_b;
    logic [7:0]         dir_a;
    logic [7:0]         dir_b;
  } state_t;

  // State after reset: reload latches all ones, line released, rest zero.
  localparam state_t STATE_RESET = {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                    8'h00, 8'h00, {STAGE_W{1'b0}}, 4'h0,
                                    5'h00, 5'h00, 1'b1, 2'b00, 2'b00, 2'b00,
                                    8'h00, 8'h00, 8'h00, 8'h00};

  // Fields of one result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_n;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       underflow_a;
    logic       underflow_b;
  } result_t;

  // Port B value with the timer outputs on bits six and seven.
  function automatic logic [7:0] port_b_value(input state_t s);
    logic [7:0] mode;
    logic [7:0] lvl;
    logic [7:0] base;
    mode = {s.pin_mode, 6'd0};
    lvl  = {s.pin_level, 6'd0};
    base = s.latch_b | ~s.dir_b;
    return (base & ~mode) | (lvl & mode);
  endfunction

endpackage
`default_nettype wire

>>> src/dtia_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtia_step
// Next-state and result logic for one tick, read or write item.
// ----------------------------------------------------------------------------
module dtia_step (
  input  wire dtia_pkg::state_t  cur,
  input  wire logic [1:0]        command,
  input  wire logic [3:0]        address,
  input  wire logic [7:0]        write_data,
  input  wire logic              count_pin,
  input  wire logic [7:0]        port_a_pins,
  input  wire logic [7:0]        port_b_pins,
  output dtia_pkg::state_t       nxt,
  output dtia_pkg::result_t      res
);
  import dtia_pkg::*;

  // Feed bits spread onto their stage positions.
  function automatic logic [STAGE_W-1:0] feed_expand(input logic [3:0] f);
    logic [STAGE_W-1:0] e;
    e = '0;
    e[CA0] = f[0];
    e[CB0] = f[1];
    e[OSA] = f[2];
    e[OSB] = f[3];
    return e;
  endfunction

  // Control register write for timer A (which=0) or B (which=1).
  function automatic state_t write_control(input state_t s, input logic which,
                                           input logic [7:0] v);
    state_t o;
    logic [7:0] rmask;
    logic [7:0] ctl;
    logic       low1;
    o = s;
    rmask = which ? RUN_MASK_B : RUN_MASK_A;
    ctl = which ? s.control_b : s.control_a;
    low1 = which ? s.stage_bits[P7L1] : s.stage_bits[P6L1];
    if ((v & rmask) == 8'h01) begin
      o.stage_bits[which ? CB0 : CA0] = 1'b1;
      o.stage_bits[which ? CB1 : CA1] = 1'b1;
      o.feed_bits[which] = 1'b1;
    end else begin
      o.stage_bits[which ? CB0 : CA0] = 1'b0;
      o.stage_bits[which ? CB1 : CA1] = 1'b0;
      o.feed_bits[which] = 1'b0;
    end
    o.feed_bits[{1'b1, which}] = v[3];
    if (v[4]) begin
      o.stage_bits[which ? LB0 : LA0] = 1'b1;
    end
    if (v[0] && !ctl[0]) begin
      o.toggle_bits[which] = 1'b1;
    end
    if (!v[1]) begin
      o.pin_mode[which] = 1'b0;
    end else begin
      o.pin_mode[which] = 1'b1;
      if (!v[2]) begin
        o.pin_level[which] = low1;
      end else begin
        o.pin_level[which] = o.toggle_bits[which];
      end
    end
    if (which) begin
      o.control_b = v;
    end else begin
      o.control_a = v;
    end
    return o;
  endfunction

  state_t t;
  state_t w;
  state_t r;
  logic [7:0] rd;
  logic ua;
  logic ub;
  logic [15:0] ca_dec;
  logic [15:0] cb_dec;

  // Tick: counters, underflows, pin outputs and interrupt delay.
  always_comb begin
    t = cur;
    ca_dec = cur.count_a - 16'd1;
    if (t.stage_bits[CA3]) begin
      t.count_a = ca_dec;
    end
    ua = (t.count_a == 16'd0) && t.stage_bits[CA2];
    if (ua) begin
      if ((t.stage_bits[OSA] | t.feed_bits[2]) != 1'b0) begin
        t.control_a[0] = 1'b0;
        t.stage_bits[CA2] = 1'b0;
        t.stage_bits[CA1] = 1'b0;
        t.stage_bits[CA0] = 1'b0;
        t.feed_bits[0] = 1'b0;
      end
      if (((t.control_b & RUN_MASK_B) == CASCADE_A) ||
          (((t.control_b & RUN_MASK_B) == CASCADE_GATED) && count_pin)) begin
        t.stage_bits[CB1] = 1'b1;
      end
      t.stage_bits[LA1] = 1'b1;
    end
    if (t.stage_bits[LA1]) begin
      t.count_a = t.reload_a;
    end
    cb_dec = cur.count_b - 16'd1;
    if (t.stage_bits[CB3]) begin
      t.count_b = cb_dec;
    end
    ub = (t.count_b == 16'd0) && t.stage_bits[CB2];
    if (ub) begin
      if ((t.stage_bits[OSB] | t.feed_bits[3]) != 1'b0) begin
        t.control_b[0] = 1'b0;
        t.stage_bits[CB2] = 1'b0;
        t.stage_bits[CB1] = 1'b0;
        t.stage_bits[CB0] = 1'b0;
        t.feed_bits[1] = 1'b0;
      end
      t.stage_bits[LB1] = 1'b1;
    end
    if (t.stage_bits[LB1]) begin
      t.count_b = t.reload_b;
    end
    if (ua) begin
      t.toggle_bits[0] = ~t.toggle_bits[0];
      if (t.control_a[1]) begin
        if (!t.control_a[2]) begin
          t.pin_level[0] = 1'b1;
          t.stage_bits[P6L0] = 1'b1;
          t.stage_bits[P6L1] = 1'b0;
        end else begin
          t.pin_level[0] = t.toggle_bits[0];
        end
      end
    end
    if (ub) begin
      t.toggle_bits[1] = ~t.toggle_bits[1];
      if (t.control_b[1]) begin
        if (!t.control_b[2]) begin
          t.pin_level[1] = 1'b1;
          t.stage_bits[P7L0] = 1'b1;
          t.stage_bits[P7L1] = 1'b0;
        end else begin
          t.pin_level[1] = t.toggle_bits[1];
        end
      end
    end
    if (t.stage_bits[P6L1]) begin
      t.pin_level[0] = 1'b0;
    end
    if (t.stage_bits[P7L1]) begin
      t.pin_level[1] = 1'b0;
    end
    if (t.stage_bits[I1]) begin
      t.line_high = 1'b0;
    end
    if (ua) begin
      t.int_status[0] = 1'b1;
    end
    if (ub) begin
      t.int_status[1] = 1'b1;
    end
    if ((ua && t.int_mask[0]) || (ub && t.int_mask[1])) begin
      t.stage_bits[I0] = 1'b1;
    end
    t.stage_bits = ({t.stage_bits[STAGE_W-2:0], 1'b0} & STAGE_KEEP) |
                   feed_expand(t.feed_bits);
  end

  // Register read, including the clear-on-read status register.
  always_comb begin
    r = cur;
    rd = 8'd0;
    case (address)
      ADDR_PRA:  rd = (cur.latch_a | ~cur.dir_a) & port_a_pins;
      ADDR_PRB:  rd = port_b_value(cur) & port_b_pins;
      ADDR_DDRA: rd = cur.dir_a;
      ADDR_DDRB: rd = cur.dir_b;
      ADDR_TALO: rd = cur.count_a[7:0];
      ADDR_TAHI: rd = cur.count_a[15:8];
      ADDR_TBLO: rd = cur.count_b[7:0];
      ADDR_TBHI: rd = cur.count_b[15:8];
      ADDR_ICR: begin
        rd = {~cur.line_high, 2'b00, cur.int_status};
        r.line_high = 1'b1;
        r.stage_bits[I0] = 1'b0;
        r.stage_bits[I1] = 1'b0;
        r.int_status = 5'd0;
      end
      ADDR_CRA:  rd = cur.control_a & 8'hEF;
      ADDR_CRB:  rd = cur.control_b & 8'hEF;
      default:   rd = 8'd0;
    endcase
  end

  // Register write.
  always_comb begin
    w = cur;
    case (address)
      ADDR_PRA:  w.latch_a = write_data;
      ADDR_PRB:  w.latch_b = write_data;
      ADDR_DDRA: w.dir_a = write_data;
      ADDR_DDRB: w.dir_b = write_data;
      ADDR_TALO: begin
        w.reload_a[7:0] = write_data;
        if (cur.stage_bits[LA2]) begin
          w.count_a[7:0] = write_data;
        end
      end
      ADDR_TAHI: begin
        w.reload_a[15:8] = write_data;
        if (!cur.control_a[0]) begin
          w.stage_bits[LA0] = 1'b1;
        end
        if (cur.stage_bits[LA2]) begin
          w.count_a[15:8] = write_data;
        end
      end
      ADDR_TBLO: begin
        w.reload_b[7:0] = write_data;
        if (cur.stage_bits[LB2]) begin
          w.count_b[7:0] = write_data;
        end
      end
      ADDR_TBHI: begin
        w.reload_b[15:8] = write_data;
        if (!cur.control_b[0]) begin
          w.stage_bits[LB0] = 1'b1;
        end
        if (cur.stage_bits[LB2]) begin
          w.count_b[15:8] = write_data;
        end
      end
      ADDR_ICR: begin
        if (write_data[7]) begin
          w.int_mask = cur.int_mask | write_data[4:0];
        end else begin
          w.int_mask = cur.int_mask & ~write_data[4:0];
        end
        if (((w.int_mask & cur.int_status) != 5'd0) && cur.line_high) begin
          w.stage_bits[I0] = 1'b1;
        end
      end
      ADDR_CRA:  w = write_control(cur, 1'b0, write_data);
      ADDR_CRB:  w = write_control(cur, 1'b1, write_data);
      default:   w = cur;
    endcase
  end

  // Select by command and form the result item.
  always_comb begin
    nxt = cur;
    res.read_data = 8'd0;
    res.underflow_a = 1'b0;
    res.underflow_b = 1'b0;
    case (cmd_t'(command))
      CMD_TICK: begin
        nxt = t;
        res.underflow_a = ua;
        res.underflow_b = ub;
      end
      CMD_READ: begin
        nxt = r;
        res.read_data = rd;
      end
      CMD_WRITE: nxt = w;
      default:   nxt = cur;
    endcase
    res.irq_n = nxt.line_high;
    res.port_a_drive = nxt.latch_a | ~nxt.dir_a;
    res.port_b_drive = port_b_value(nxt);
  end

endmodule
`default_nettype wire

>>> src/dual_timer_interrupt_adapter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_timer_interrupt_adapter_core
// Two cascadable 16-bit timers with interrupt logic and two 8-bit ports.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid/in_ready    command, address, write_data, count_pin,
//                                 port_a_pins, port_b_pins
//  output    out_valid/out_ready  read_data, irq_n, port_a_drive,
//                                 port_b_drive, underflow_a, underflow_b
//
//  Each item updates the state in the cycle it is accepted; its result is
//  registered and visible in the cycle after. One item per cycle is sustained while each result is taken.
//  While a result waits, a new item is still taken if the result leaves
//  in the same cycle; the single result register sets this limit.
//  Reset (rst, synchronous) restores every timer, latch and port register.
// ----------------------------------------------------------------------------
module dual_timer_interrupt_adapter_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  input  wire logic [3:0] address,
  input  wire logic [7:0] write_data,
  input  wire logic       count_pin,
  input  wire logic [7:0] port_a_pins,
  input  wire logic [7:0] port_b_pins,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_data,
  output logic            irq_n,
  output logic [7:0]      port_a_drive,
  output logic [7:0]      port_b_drive,
  output logic            underflow_a,
  output logic            underflow_b
);
  import dtia_pkg::*;

  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t res;
  logic    accept;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  dtia_step u_step (
    .cur         (state),
    .command     (command),
    .address     (address),
    .write_data  (write_data),
    .count_pin   (count_pin),
    .port_a_pins (port_a_pins),
    .port_b_pins (port_b_pins),
    .nxt         (state_next),
    .res         (res_next)
  );

  // Adapter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign read_data    = res.read_data;
  assign irq_n        = res.irq_n;
  assign port_a_drive = res.port_a_drive;
  assign port_b_drive = res.port_b_drive;
  assign underflow_a  = res.underflow_a;
  assign underflow_b  = res.underflow_b;

  // A non-tick item never reports an underflow.
  assert property (@(posedge clk) disable iff (rst)
    accept && command != CMD_TICK |=> !underflow_a && !underflow_b)
    else $error("underflow reported on non-tick item");

  // Only a read item returns nonzero data.
  assert property (@(posedge clk) disable iff (rst)
    accept && command != CMD_READ |=> read_data == 8'd0)
    else $error("read data on non-read item");

  // A status read always releases the interrupt line.
  assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_READ && address == ADDR_ICR |=> irq_n)
    else $error("status read left line asserted");

  // The state holds while no item is accepted.
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state))
    else $error("state changed without an item");

endmodule
`default_nettype wire

>>> bench/dual_timer_interrupt_adapter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_timer_interrupt_adapter_core_tb
// Drives ticks, register reads and register writes into the adapter. A
// cycle-level predictor of the timers, stage pipeline, interrupt logic and
// ports works out each result as items are accepted. The monitor checks
// every result field against the oldest prediction. Both sides idle at
// random, and the receiver holds off for one long stretch.
// ----------------------------------------------------------------------------
module dual_timer_interrupt_adapter_core_tb;
  import dtia_pkg::*;

  typedef struct {
    cmd_t       cmd;
    logic [3:0] addr;
    logic [7:0] data;
    logic       cnt;
    logic [7:0] pa;
    logic [7:0] pb;
    bit         sync;
  } access_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = 2'd0;
  logic [3:0] address = 4'd0;
  logic [7:0] write_data = 8'd0;
  logic count_pin = 1'b0;
  logic [7:0] port_a_pins = 8'd0;
  logic [7:0] port_b_pins = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] read_data;
  logic irq_n;
  logic [7:0] port_a_drive;
  logic [7:0] port_b_drive;
  logic underflow_a;
  logic underflow_b;

  access_t pending_q[$];
  result_t expected_q[$];
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;

  // Predictor state.
  logic [15:0] cnt_a, rel_a, cnt_b, rel_b;
  logic [7:0] ctl_a, ctl_b;
  logic [STAGE_W-1:0] stg;
  logic [3:0] feed;
  logic [4:0] icr_status, icr_mask;
  logic line_up;
  logic [1:0] pmode, plevel, ptoggle;
  logic [7:0] lat_a, lat_b, ddr_a, ddr_b;

  dual_timer_interrupt_adapter_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .address(address), .write_data(write_data),
    .count_pin(count_pin), .port_a_pins(port_a_pins), .port_b_pins(port_b_pins),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .irq_n(irq_n), .port_a_drive(port_a_drive),
    .port_b_drive(port_b_drive), .underflow_a(underflow_a), .underflow_b(underflow_b)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [STAGE_W-1:0] feed_stages();
    logic [STAGE_W-1:0] s;
    s = '0;
    s[CA0] = feed[0];
    s[CB0] = feed[1];
    s[OSA] = feed[2];
    s[OSB] = feed[3];
    return s;
  endfunction

  function automatic logic [7:0] port_b_out();
    logic [7:0] m;
    logic [7:0] l;
    m = {pmode, 6'd0};
    l = {plevel, 6'd0};
    return ((lat_b | ~ddr_b) & ~m) | (l & m);
  endfunction

  task automatic clear_model();
    cnt_a = '0; rel_a = 16'hFFFF; cnt_b = '0; rel_b = 16'hFFFF;
    ctl_a = '0; ctl_b = '0; stg = '0; feed = '0;
    icr_status = '0; icr_mask = '0; line_up = 1'b1;
    pmode = '0; plevel = '0; ptoggle = '0;
    lat_a = '0; lat_b = '0; ddr_a = '0; ddr_b = '0;
  endtask

  // Control register write; sel 0 is timer A, 1 is timer B.
  task automatic put_control(input bit sel, input logic [7:0] v);
    logic [7:0] run;
    int c0, c1, ld0, low1, p;
    run = sel ? RUN_MASK_B : RUN_MASK_A;
    c0 = sel ? CB0 : CA0;
    c1 = sel ? CB1 : CA1;
    ld0 = sel ? LB0 : LA0;
    low1 = sel ? P7L1 : P6L1;
    p = sel ? 1 : 0;
    if ((v & run) == 8'h01) begin
      stg[c1] = 1'b1; stg[c0] = 1'b1; feed[p] = 1'b1;
    end else begin
      stg[c1] = 1'b0; stg[c0] = 1'b0; feed[p] = 1'b0;
    end
    feed[2 + p] = v[3];
    if (v[4]) stg[ld0] = 1'b1;
    if (v[0] && !(sel ? ctl_b[0] : ctl_a[0])) ptoggle[p] = 1'b1;
    if (!v[1]) begin
      pmode[p] = 1'b0;
    end else begin
      pmode[p] = 1'b1;
      plevel[p] = v[2] ? ptoggle[p] : stg[low1];
    end
    if (sel) ctl_b = v; else ctl_a = v;
  endtask

  // Timer output event on underflow: one-tick pulse or toggle.
  task automatic timer_pin(input logic [7:0] ctl, input int p, input int low0,
                           input int low1);
    ptoggle[p] = ~ptoggle[p];
    if (ctl[1]) begin
      if (!ctl[2]) begin
        plevel[p] = 1'b1; stg[low0] = 1'b1; stg[low1] = 1'b0;
      end else begin
        plevel[p] = ptoggle[p];
      end
    end
  endtask

  task automatic clock_tick(input logic cnt, output logic ua, output logic ub);
    if (stg[CA3]) cnt_a = cnt_a - 16'd1;
    ua = (cnt_a == 16'd0) && stg[CA2];
    if (ua) begin
      if ((stg | feed_stages()) & (1 << OSA)) begin
        ctl_a[0] = 1'b0;
        stg[CA2] = 1'b0; stg[CA1] = 1'b0; stg[CA0] = 1'b0; feed[0] = 1'b0;
      end
      if ((ctl_b & RUN_MASK_B) == CASCADE_A || ((ctl_b & RUN_MASK_B) == CASCADE_GATED && cnt))
        stg[CB1] = 1'b1;
      stg[LA1] = 1'b1;
    end
    if (stg[LA1]) cnt_a = rel_a;
    if (stg[CB3]) cnt_b = cnt_b - 16'd1;
    ub = (cnt_b == 16'd0) && stg[CB2];
    if (ub) begin
      if ((stg | feed_stages()) & (1 << OSB)) begin
        ctl_b[0] = 1'b0;
        stg[CB2] = 1'b0; stg[CB1] = 1'b0; stg[CB0] = 1'b0; feed[1] = 1'b0;
      end
      stg[LB1] = 1'b1;
    end
    if (stg[LB1]) cnt_b = rel_b;
    if (ua) timer_pin(ctl_a, 0, P6L0, P6L1);
    if (ub) timer_pin(ctl_b, 1, P7L0, P7L1);
    if (stg[P6L1]) plevel[0] = 1'b0;
    if (stg[P7L1]) plevel[1] = 1'b0;
    if (stg[I1]) line_up = 1'b0;
    if (ua) icr_status[0] = 1'b1;
    if (ub) icr_status[1] = 1'b1;
    if ((ua && icr_mask[0]) || (ub && icr_mask[1])) stg[I0] = 1'b1;
    stg = ((stg << 1) & STAGE_KEEP) | feed_stages();
  endtask

  function automatic logic [7:0] reg_fetch(input logic [3:0] a, input logic [7:0] pa,
                                           input logic [7:0] pb);
    logic [7:0] r;
    r = 8'd0;
    case (a)
      ADDR_PRA:  r = (lat_a | ~ddr_a) & pa;
      ADDR_PRB:  r = port_b_out() & pb;
      ADDR_DDRA: r = ddr_a;
      ADDR_DDRB: r = ddr_b;
      ADDR_TALO: r = cnt_a[7:0];
      ADDR_TAHI: r = cnt_a[15:8];
      ADDR_TBLO: r = cnt_b[7:0];
      ADDR_TBHI: r = cnt_b[15:8];
      ADDR_ICR: begin
        // Reading the status releases the line and drops pending interrupts.
        r = {3'd0, icr_status};
        if (!line_up) begin
          r[7] = 1'b1;
          line_up = 1'b1;
        end
        stg[I0] = 1'b0; stg[I1] = 1'b0;
        icr_status = '0;
      end
      ADDR_CRA:  r = ctl_a & 8'hEF;
      ADDR_CRB:  r = ctl_b & 8'hEF;
      default:   r = 8'd0;
    endcase
    return r;
  endfunction

  task automatic reg_store(input logic [3:0] a, input logic [7:0] v);
    case (a)
      ADDR_PRA:  lat_a = v;
      ADDR_PRB:  lat_b = v;
      ADDR_DDRA: ddr_a = v;
      ADDR_DDRB: ddr_b = v;
      ADDR_TALO: begin
        rel_a[7:0] = v;
        if (stg[LA2]) cnt_a[7:0] = v;
      end
      ADDR_TAHI: begin
        rel_a[15:8] = v;
        if (!ctl_a[0]) stg[LA0] = 1'b1;
        if (stg[LA2]) cnt_a[15:8] = v;
      end
      ADDR_TBLO: begin
        rel_b[7:0] = v;
        if (stg[LB2]) cnt_b[7:0] = v;
      end
      ADDR_TBHI: begin
        rel_b[15:8] = v;
        if (!ctl_b[0]) stg[LB0] = 1'b1;
        if (stg[LB2]) cnt_b[15:8] = v;
      end
      ADDR_ICR: begin
        if (v[7]) icr_mask = icr_mask | v[4:0];
        else icr_mask = icr_mask & ~v[4:0];
        if ((icr_mask & icr_status) != 0 && line_up) stg[I0] = 1'b1;
      end
      ADDR_CRA:  put_control(1'b0, v);
      ADDR_CRB:  put_control(1'b1, v);
      default: ;
    endcase
  endtask

  // Apply one accepted item to the predictor and queue its result.
  task automatic predict_access(input access_t it);
    result_t r;
    logic ua, ub;
    r = '0;
    ua = 1'b0;
    ub = 1'b0;
    case (it.cmd)
      CMD_TICK:  clock_tick(it.cnt, ua, ub);
      CMD_READ:  r.read_data = reg_fetch(it.addr, it.pa, it.pb);
      CMD_WRITE: reg_store(it.addr, it.data);
      default: ;
    endcase
    r.irq_n = line_up;
    r.port_a_drive = lat_a | ~ddr_a;
    r.port_b_drive = port_b_out();
    r.underflow_a = ua;
    r.underflow_b = ub;
    expected_q.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_item(input cmd_t c, input logic [3:0] a, input logic [7:0] d,
                          input bit sync = 1'b0);
    access_t it;
    it.cmd = c; it.addr = a; it.data = d; it.sync = sync;
    it.cnt = 1'($urandom_range(0, 1));
    it.pa = 8'($urandom_range(0, 255));
    it.pb = 8'($urandom_range(0, 255));
    pending_q.push_back(it);
  endtask

  // One timer setup with random content followed by mostly ticks, some random accesses and a status read.
  task automatic add_timer_run();
    int n;
    add_item(CMD_WRITE, ADDR_TALO, 8'($urandom_range(0, 6)));
    add_item(CMD_WRITE, ADDR_TAHI,
             ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'd0);
    add_item(CMD_WRITE, ADDR_TBLO, 8'($urandom_range(0, 4)));
    add_item(CMD_WRITE, ADDR_TBHI, 8'd0);
    add_item(CMD_WRITE, ADDR_ICR, 8'($urandom_range(0, 255)));
    add_item(CMD_WRITE, ADDR_CRB, 8'($urandom_range(0, 255)));
    add_item(CMD_WRITE, ADDR_CRA, 8'($urandom_range(0, 255)));
    n = $urandom_range(6, 30);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1:    add_item(CMD_READ, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        2:       add_item(CMD_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        3:       add_item(CMD_NONE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        4:       add_item(CMD_READ, ADDR_ICR, 8'd0);
        default: add_item(CMD_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      endcase
    end
    add_item(CMD_READ, ADDR_ICR, 8'd0);
  endtask

  // Stimulus: directed corners first, then mostly well-formed timer runs.
  initial begin
    clear_model();
    for (int a = 0; a < 16; a++) add_item(CMD_READ, 4'(a), 8'd0);
    add_item(CMD_NONE, 4'hF, 8'hFF);
    add_item(CMD_WRITE, ADDR_DDRA, 8'hFF);
    add_item(CMD_WRITE, ADDR_PRA, 8'hA5);
    add_item(CMD_WRITE, ADDR_DDRB, 8'h0F);
    add_item(CMD_WRITE, ADDR_PRB, 8'hFF);
    add_item(CMD_WRITE, 4'd9, 8'h55);
    add_item(CMD_WRITE, ADDR_ICR, 8'h9F, 1'b1);
    add_item(CMD_WRITE, ADDR_TALO, 8'd2);
    add_item(CMD_WRITE, ADDR_TAHI, 8'd0);
    add_item(CMD_WRITE, ADDR_CRA, 8'h13);
    add_item(CMD_WRITE, ADDR_CRB, 8'h47);
    repeat (10) add_item(CMD_TICK, 4'd0, 8'd0);
    add_item(CMD_READ, ADDR_ICR, 8'd0);
    add_item(CMD_WRITE, ADDR_CRA, 8'h0F);
    add_item(CMD_WRITE, ADDR_ICR, 8'h01);
    repeat (8) add_item(CMD_TICK, 4'd0, 8'd0);
    add_item(CMD_READ, ADDR_ICR, 8'd0, 1'b1);
    while (pending_q.size() < 1350) begin
      if ($urandom_range(0, 9) < 8) begin
        add_timer_run();
      end else begin
        repeat (10) add_item(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 19) == 0) pending_q[pending_q.size() - 1].sync = 1'b1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: present items, predict each on acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_access('{cmd_t'(command), address, write_data, count_pin,
                         port_a_pins, port_b_pins, 1'b0});
        sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].sync && (expected_q.size() != 0 || in_valid))) begin
          in_valid <= 1'b0;
        end else begin
          access_t it;
          it = pending_q.pop_front();
          command <= it.cmd;
          address <= it.addr;
          write_data <= it.data;
          count_pin <= it.cnt;
          port_a_pins <= it.pa;
          port_b_pins <= it.pb;
          in_valid <= 1'b1;
          send_gap = ((sent / 150) % 3 == 1) ? 0 : pick_gap();
        end
      end
    end
  end

  // Monitor: accept results and compare field by field.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (e.read_data !== read_data || e.irq_n !== irq_n ||
              e.port_a_drive !== port_a_drive || e.port_b_drive !== port_b_drive ||
              e.underflow_a !== underflow_a || e.underflow_b !== underflow_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("item %0d: expected rd=%h irq_n=%b pa=%h pb=%h ua=%b ub=%b, got rd=%h irq_n=%b pa=%h pb=%h ua=%b ub=%b",
                       received, e.read_data, e.irq_n, e.port_a_drive, e.port_b_drive,
                       e.underflow_a, e.underflow_b, read_data, irq_n, port_a_drive,
                       port_b_drive, underflow_a, underflow_b);
          end
        end
        received++;
        // One long hold-off so that the block backs up and stalls its input.
        if (received == 400) hold_off = 300;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = ((received / 200) % 3 == 2) ? 0 : pick_gap();
      end
    end
  end

  // End of run once every item is through.
  initial begin
    @(negedge rst);
    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("dual_timer_interrupt_adapter_core_tb: clean");
    end else begin
      $display("dual_timer_interrupt_adapter_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("dual_timer_interrupt_adapter_core_tb: errors");
    $finish;
  end

endmodule

>>> files.f
src/dtia_pkg.sv
src/dtia_step.sv
src/dual_timer_interrupt_adapter_core.sv
bench/dual_timer_interrupt_adapter_core_tb.sv
